@@ src/fpp_pkg.sv @@
`default_nettype none
package fpp_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_BITS = 2;
    localparam int QUEUE_CNT_BITS = 3;

    localparam logic [3:0] PIECE_PAWN   = 4'd0;
    localparam logic [3:0] PIECE_KNIGHT = 4'd1;
    localparam logic [3:0] PIECE_BISHOP = 4'd2;
    localparam logic [3:0] PIECE_ROOK   = 4'd3;
    localparam logic [3:0] PIECE_QUEEN  = 4'd4;
    localparam logic [3:0] PIECE_KING   = 4'd5;
    localparam logic [3:0] BLACK_OFFSET = 4'd6;

    localparam logic KIND_PLACE  = 1'b0;
    localparam logic KIND_RECORD = 1'b1;

    localparam logic CMD_CHAR = 1'b0;
    localparam logic CMD_END  = 1'b1;

    typedef struct packed {
        logic       eot;
        logic       space;
        logic       digit;
        logic [3:0] digit_val;
        logic       slash;
        logic       piece;
        logic [3:0] piece_code;
        logic [3:0] castle;
        logic       dash;
        logic       white;
        logic       black;
        logic       ep_file_ok;
        logic [2:0] ep_file;
        logic       ep_rank_ok;
        logic [2:0] ep_rank;
    } fpp_item_t;

    typedef struct packed {
        logic        kind;
        logic [5:0]  square;
        logic [3:0]  piece;
        logic        side;
        logic [3:0]  rights;
        logic        ep_valid;
        logic [5:0]  ep_square;
        logic [15:0] fifty_ply;
        logic [15:0] history_ply;
        logic        error;
    } fpp_result_t;

endpackage
`default_nettype wire

@@ src/fpp_classify.sv @@
`default_nettype none
module fpp_classify
    import fpp_pkg::*;
(
    input  wire logic       command,
    input  wire logic [7:0] ch,
    output fpp_item_t       item
);

    localparam logic [7:0] CH_SPACE = " ";
    localparam logic [7:0] CH_SLASH = "/";
    localparam logic [7:0] CH_DASH  = "-";
    localparam logic [7:0] CH_ZERO  = "0";
    localparam logic [7:0] CH_ONE   = "1";
    localparam logic [7:0] CH_NINE  = "9";
    localparam logic [7:0] CH_EIGHT = "8";
    localparam logic [7:0] CH_UP_A  = "A";
    localparam logic [7:0] CH_UP_Z  = "Z";
    localparam logic [7:0] CH_LO_A  = "a";
    localparam logic [7:0] CH_LO_H  = "h";
    localparam logic [7:0] CH_LO_Z  = "z";
    localparam logic [7:0] CH_UP_K  = "K";
    localparam logic [7:0] CH_UP_Q  = "Q";
    localparam logic [7:0] CH_LO_K  = "k";
    localparam logic [7:0] CH_LO_Q  = "q";
    localparam logic [7:0] CH_LO_W  = "w";
    localparam logic [7:0] CH_LO_B  = "b";
    localparam logic [7:0] CASE_GAP = 8'd32;

    logic       upper;
    logic       lower;
    logic [7:0] up_ch;
    logic [7:0] digit_off;
    logic [7:0] file_off;
    logic [7:0] rank_off;
    logic       type_ok;
    logic [3:0] type_code;

    assign upper     = (ch >= CH_UP_A) && (ch <= CH_UP_Z);
    assign lower     = (ch >= CH_LO_A) && (ch <= CH_LO_Z);
    assign up_ch     = lower ? ch - CASE_GAP : ch;
    assign digit_off = ch - CH_ZERO;
    assign file_off  = ch - CH_LO_A;
    assign rank_off  = ch - CH_ONE;

    always_comb begin
        type_ok   = 1'b1;
        type_code = PIECE_PAWN;
        unique case (up_ch)
            "P":     type_code = PIECE_PAWN;
            "N":     type_code = PIECE_KNIGHT;
            "B":     type_code = PIECE_BISHOP;
            "R":     type_code = PIECE_ROOK;
            "Q":     type_code = PIECE_QUEEN;
            "K":     type_code = PIECE_KING;
            default: type_ok = 1'b0;
        endcase
    end

    always_comb begin
        item            = '0;
        item.eot        = (command == CMD_END);
        item.space      = (ch == CH_SPACE);
        item.digit      = (ch >= CH_ZERO) && (ch <= CH_NINE);
        item.digit_val  = digit_off[3:0];
        item.slash      = (ch == CH_SLASH);
        item.piece      = (upper || lower) && type_ok;
        item.piece_code = upper ? type_code : type_code + BLACK_OFFSET;
        item.castle     = {ch == CH_LO_Q, ch == CH_LO_K, ch == CH_UP_Q, ch == CH_UP_K};
        item.dash       = (ch == CH_DASH);
        item.white      = (ch == CH_LO_W);
        item.black      = (ch == CH_LO_B);
        item.ep_file_ok = (ch >= CH_LO_A) && (ch <= CH_LO_H);
        item.ep_file    = file_off[2:0];
        item.ep_rank_ok = (ch >= CH_ONE) && (ch <= CH_EIGHT);
        item.ep_rank    = rank_off[2:0];
    end

endmodule
`default_nettype wire

@@ src/fpp_queue.sv @@
`default_nettype none
module fpp_queue
    import fpp_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push_valid,
    output logic      push_ready,
    input  wire fpp_item_t push_item,
    output logic      pop_valid,
    input  wire logic pop_ready,
    output fpp_item_t pop_item
);

    fpp_item_t                 slot_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_BITS-1:0] count_reg, count_next;
    logic                      push;
    logic                      pop;

    assign push_ready = (count_reg != QUEUE_CNT_BITS'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = slot_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QUEUE_CNT_BITS'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_ptr_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1)
            && (wr_ptr_reg == $past(wr_ptr_reg) + 1'b1))
        else $error("queue push lost");
`endif

endmodule
`default_nettype wire

@@ src/fpp_parser.sv @@
`default_nettype none
module fpp_parser
    import fpp_pkg::*;
#(
    parameter int PLY_COUNT_BITS = 16
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire fpp_item_t in_item,
    output logic      out_valid,
    input  wire logic out_ready,
    output fpp_result_t out_result
);

    localparam int SUM_BITS  = PLY_COUNT_BITS + 4;
    localparam int WIDE_BITS = PLY_COUNT_BITS + 16;

    typedef enum logic [2:0] {
        PH_LEAD   = 3'd0,
        PH_BOARD  = 3'd1,
        PH_SIDE   = 3'd2,
        PH_CASTLE = 3'd3,
        PH_EP     = 3'd4,
        PH_FIFTY  = 3'd5,
        PH_HIST   = 3'd6,
        PH_DONE   = 3'd7
    } phase_t;

    localparam logic [3:0] FILE_OFF = 4'd8;
    localparam logic [3:0] RANK_TOP = 4'd7;
    localparam logic [3:0] RANK_OFF = 4'd15;
    localparam logic [1:0] TOK_START = 2'd0;
    localparam logic [1:0] TOK_MID   = 2'd1;
    localparam logic [1:0] TOK_SKIP  = 2'd2;

    phase_t                    phase_reg, phase_next, eff_phase;
    logic [3:0]                file_reg, file_next;
    logic [3:0]                rank_reg, rank_next;
    logic                      in_token_reg, in_token_next;
    logic [1:0]                tok_reg, tok_next, tok_cur;
    logic                      side_reg, side_next;
    logic [3:0]                rights_reg, rights_next;
    logic                      ep_flag_reg, ep_flag_next;
    logic [2:0]                ep_file_reg, ep_file_next;
    logic [5:0]                ep_index_reg, ep_index_next;
    logic [PLY_COUNT_BITS-1:0] fifty_reg, fifty_next;
    logic [PLY_COUNT_BITS-1:0] hist_reg, hist_next;
    logic                      err_reg, err_next;
    logic                      out_valid_reg, out_valid_next;
    fpp_result_t               res_reg, res_next;

    logic                      pop;
    logic                      emit;
    logic                      do_tok;
    logic                      trunc;
    logic [4:0]                file_sum;
    logic [PLY_COUNT_BITS-1:0] count_cur;
    logic [SUM_BITS-1:0]       count_wide;
    logic [SUM_BITS-1:0]       count_sum;
    logic [PLY_COUNT_BITS-1:0] count_sat;
    logic [WIDE_BITS-1:0]      fifty_wide;
    logic [WIDE_BITS-1:0]      hist_wide;

    assign in_ready  = !out_valid_reg || out_ready;
    assign pop       = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_result = res_reg;

    assign file_sum   = {1'b0, file_reg} + {1'b0, in_item.digit_val};
    assign count_cur  = (phase_reg == PH_FIFTY) ? fifty_reg : hist_reg;
    assign count_wide = {4'b0, count_cur};
    assign count_sum  = (count_wide << 3) + (count_wide << 1)
                        + {{(SUM_BITS-4){1'b0}}, in_item.digit_val};
    assign count_sat  = (|count_sum[SUM_BITS-1:PLY_COUNT_BITS]) ? '1
                        : count_sum[PLY_COUNT_BITS-1:0];
    assign fifty_wide = {16'b0, fifty_reg};
    assign hist_wide  = {16'b0, hist_reg};
    assign trunc      = (phase_reg < PH_EP)
                        || (phase_reg == PH_EP && (!in_token_reg || tok_reg == TOK_MID));
    assign eff_phase  = (phase_reg == PH_LEAD && !in_item.space) ? PH_BOARD : phase_reg;

    always_comb begin
        phase_next    = phase_reg;
        file_next     = file_reg;
        rank_next     = rank_reg;
        in_token_next = in_token_reg;
        tok_next      = tok_reg;
        side_next     = side_reg;
        rights_next   = rights_reg;
        ep_flag_next  = ep_flag_reg;
        ep_file_next  = ep_file_reg;
        ep_index_next = ep_index_reg;
        fifty_next    = fifty_reg;
        hist_next     = hist_reg;
        err_next      = err_reg;
        emit          = 1'b0;
        do_tok        = 1'b0;
        tok_cur       = tok_reg;
        res_next      = '0;

        if (in_item.eot) begin
            emit                 = 1'b1;
            res_next.kind        = KIND_RECORD;
            res_next.side        = side_reg;
            res_next.rights      = rights_reg;
            res_next.ep_valid    = ep_flag_reg;
            res_next.ep_square   = ep_flag_reg ? ep_index_reg : 6'd0;
            res_next.fifty_ply   = fifty_wide[15:0];
            res_next.history_ply = hist_wide[15:0];
            res_next.error       = err_reg || trunc;
            phase_next    = PH_LEAD;
            file_next     = '0;
            rank_next     = RANK_TOP;
            in_token_next = 1'b0;
            tok_next      = TOK_START;
            side_next     = 1'b0;
            rights_next   = '0;
            ep_flag_next  = 1'b0;
            ep_file_next  = '0;
            ep_index_next = '0;
            fifty_next    = '0;
            hist_next     = '0;
            err_next      = 1'b0;
        end else if (phase_reg == PH_LEAD && in_item.space) begin
            phase_next = PH_LEAD;
        end else if (eff_phase == PH_BOARD) begin
            phase_next = PH_BOARD;
            if (in_item.space) begin
                phase_next    = PH_SIDE;
                in_token_next = 1'b0;
                tok_next      = TOK_START;
            end else if (in_item.digit) begin
                file_next = (file_sum > {1'b0, FILE_OFF}) ? FILE_OFF : file_sum[3:0];
            end else if (in_item.slash) begin
                file_next = '0;
                rank_next = (rank_reg == '0 || rank_reg > RANK_TOP) ? RANK_OFF
                            : rank_reg - 1'b1;
            end else if (!in_item.piece) begin
                err_next = 1'b1;
            end else if (file_reg > RANK_TOP || rank_reg > RANK_TOP) begin
                err_next = 1'b1;
                if (file_reg < FILE_OFF) begin
                    file_next = file_reg + 1'b1;
                end
            end else begin
                emit            = 1'b1;
                res_next.kind   = KIND_PLACE;
                res_next.square = {rank_reg[2:0], file_reg[2:0]};
                res_next.piece  = in_item.piece_code;
                file_next       = file_reg + 1'b1;
            end
        end else if (phase_reg == PH_DONE) begin
            phase_next = PH_DONE;
        end else if (!in_token_reg) begin
            if (!in_item.space) begin
                in_token_next = 1'b1;
                tok_next      = TOK_START;
                tok_cur       = TOK_START;
                do_tok        = 1'b1;
            end
        end else if (in_item.space) begin
            if (phase_reg == PH_EP && tok_reg == TOK_MID) begin
                err_next = 1'b1;
            end
            phase_next    = phase_t'(phase_reg + 3'd1);
            in_token_next = 1'b0;
            tok_next      = TOK_START;
        end else begin
            do_tok = 1'b1;
        end

        if (do_tok) begin
            unique case (phase_reg)
                PH_SIDE: begin
                    if (tok_cur == TOK_START) begin
                        if (in_item.white) begin
                            side_next = 1'b0;
                        end else if (in_item.black) begin
                            side_next = 1'b1;
                        end else begin
                            err_next = 1'b1;
                        end
                        tok_next = TOK_MID;
                    end
                end
                PH_CASTLE: begin
                    if (tok_cur == TOK_SKIP) begin
                        tok_next = TOK_SKIP;
                    end else if (tok_cur == TOK_START && in_item.dash) begin
                        tok_next = TOK_SKIP;
                    end else begin
                        tok_next    = TOK_MID;
                        rights_next = rights_reg | in_item.castle;
                        if (in_item.castle == '0) begin
                            err_next = 1'b1;
                        end
                    end
                end
                PH_EP: begin
                    if (tok_cur == TOK_START) begin
                        if (in_item.dash) begin
                            tok_next = TOK_SKIP;
                        end else if (in_item.ep_file_ok) begin
                            ep_file_next = in_item.ep_file;
                            tok_next     = TOK_MID;
                        end else begin
                            err_next = 1'b1;
                            tok_next = TOK_SKIP;
                        end
                    end else if (tok_cur == TOK_MID) begin
                        if (in_item.ep_rank_ok) begin
                            ep_flag_next  = 1'b1;
                            ep_index_next = {in_item.ep_rank, ep_file_reg};
                        end else begin
                            err_next = 1'b1;
                        end
                        tok_next = TOK_SKIP;
                    end
                end
                PH_FIFTY, PH_HIST: begin
                    if (tok_cur == TOK_START) begin
                        if (!in_item.digit) begin
                            tok_next = TOK_SKIP;
                        end else if (phase_reg == PH_FIFTY) begin
                            fifty_next = count_sat;
                        end else begin
                            hist_next = count_sat;
                        end
                    end
                end
                default: begin
                    tok_next = tok_reg;
                end
            endcase
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (pop && emit) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_LEAD;
            file_reg      <= '0;
            rank_reg      <= RANK_TOP;
            in_token_reg  <= 1'b0;
            tok_reg       <= TOK_START;
            side_reg      <= 1'b0;
            rights_reg    <= '0;
            ep_flag_reg   <= 1'b0;
            ep_file_reg   <= '0;
            ep_index_reg  <= '0;
            fifty_reg     <= '0;
            hist_reg      <= '0;
            err_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (pop) begin
                phase_reg    <= phase_next;
                file_reg     <= file_next;
                rank_reg     <= rank_next;
                in_token_reg <= in_token_next;
                tok_reg      <= tok_next;
                side_reg     <= side_next;
                rights_reg   <= rights_next;
                ep_flag_reg  <= ep_flag_next;
                ep_file_reg  <= ep_file_next;
                ep_index_reg <= ep_index_next;
                fifty_reg    <= fifty_next;
                hist_reg     <= hist_next;
                err_reg      <= err_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop && emit) begin
            res_reg <= res_next;
        end
    end

`ifndef SYNTHESIS
    a_file_range: assert property (@(posedge aclk) disable iff (!aresetn)
        file_reg <= FILE_OFF)
        else $error("file position beyond off-board mark");

    a_rank_range: assert property (@(posedge aclk) disable iff (!aresetn)
        rank_reg <= RANK_TOP || rank_reg == RANK_OFF)
        else $error("rank position corrupt");

    a_eot_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && in_item.eot) |=> (phase_reg == PH_LEAD && out_valid_reg
            && res_reg.kind == KIND_RECORD && err_reg == 1'b0))
        else $error("end of text did not emit record and clear");
`endif

endmodule
`default_nettype wire

@@ src/fen_position_parser.sv @@
`default_nettype none
// Accepted characters are classified and queued; results are registered at the output.
// Throughput: one item per cycle while the queue is not full; the parser back end
// retires one queued item per cycle while the output register is free or being taken.
// A four-entry queue lets the input keep flowing while the output stalls.
// Reset: synchronous active-low aresetn clears queue, parser state and valid.
module fen_position_parser
    import fpp_pkg::*;
#(
    parameter int PLY_COUNT_BITS = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,  // ch
    input  wire logic [0:0]  s_tuser,  // command
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata,  // square, piece, side, rights, ep_valid,
                                       // ep_square, fifty_ply, history_ply, error
    output logic [0:0]       m_tuser   // kind
);

    fpp_item_t   cls_item;
    fpp_item_t   q_item;
    logic        q_valid;
    logic        q_ready;
    fpp_result_t result;

    fpp_classify u_classify (
        .command (s_tuser[0]),
        .ch      (s_tdata),
        .item    (cls_item)
    );

    fpp_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (s_tvalid),
        .push_ready (s_tready),
        .push_item  (cls_item),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_item   (q_item)
    );

    fpp_parser #(
        .PLY_COUNT_BITS (PLY_COUNT_BITS)
    ) u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (q_valid),
        .in_ready   (q_ready),
        .in_item    (q_item),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (result)
    );

    assign m_tuser = result.kind;
    assign m_tdata = {1'b0, result.error, result.history_ply, result.fifty_ply,
                      result.ep_square, result.ep_valid, result.rights, result.side,
                      result.piece, result.square};

endmodule
`default_nettype wire
